// File: rtl/indexed_insert_erase_list_core_defines.svh
// assertion macros shared by the checker
`ifndef INDEXED_INSERT_ERASE_LIST_CORE_DEFINES_SVH
`define INDEXED_INSERT_ERASE_LIST_CORE_DEFINES_SVH

// same-cycle implication, sampled on the block clock
`define IIEL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("list core check failed");

// next-cycle implication, sampled on the block clock
`define IIEL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("list core check failed");

`endif

// File: rtl/iiel_pkg.sv
package iiel_pkg;

    localparam int LIST_DEPTH = 16;

    localparam int OP_W    = 2;
    localparam int INDEX_W = 4;
    localparam int WORD_W  = 32;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam int AW    = $clog2(LIST_DEPTH);
    localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_ERASE  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_ERASE  = 2'd1,
        KIND_READ   = 2'd2,
        KIND_NOP    = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t                     kind;
        logic [INDEX_W-1:0]        index;
        logic signed [WORD_W-1:0]  value;
    } cmd_t;

endpackage

// File: rtl/iiel_front.sv
module iiel_front import iiel_pkg::*;
(
    input  logic                      push,
    output logic                      full,
    input  logic [OP_W-1:0]           op,
    input  logic [INDEX_W-1:0]        index,
    input  logic signed [WORD_W-1:0]  value,
    output logic                      q_push,
    output cmd_t                      q_cmd,
    input  logic                      q_full
);

    kind_t kind;

    always_comb
    begin
        case (op)
            OP_INSERT: kind = KIND_INSERT;
            OP_ERASE:  kind = KIND_ERASE;
            OP_READ:   kind = KIND_READ;
            default:   kind = KIND_NOP;
        endcase
    end

    assign full         = q_full;
    assign q_push       = push && !q_full;
    assign q_cmd.kind   = kind;
    assign q_cmd.index  = index;
    // value only matters for insert, keep it clean otherwise
    assign q_cmd.value  = (kind == KIND_INSERT) ? value : '0;

endmodule

// File: rtl/iiel_queue.sv
module iiel_queue import iiel_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  cmd_t  push_cmd,
    output logic  full,
    input  logic  pop,
    output logic  empty,
    output cmd_t  head
);

    cmd_t              slot_reg [Q_DEPTH];
    logic [Q_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CW-1:0]   used_reg, used_next;
    logic              do_push, do_pop;

    assign full    = (used_reg == Q_CW'(Q_DEPTH));
    assign empty   = (used_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        used_next   = used_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            used_next = used_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            used_next = used_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            used_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            used_reg   <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: rtl/iiel_back.sv
module iiel_back import iiel_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cmd_valid,
    input  cmd_t                      cmd,
    output logic                      cmd_take,
    output logic                      empty,
    input  logic                      pop,
    output logic [STAT_W-1:0]         status,
    output logic [COUNT_W-1:0]        count,
    output logic signed [WORD_W-1:0]  read_value
);

    logic signed [WORD_W-1:0]  entry_reg  [LIST_DEPTH];
    logic signed [WORD_W-1:0]  entry_next [LIST_DEPTH];
    logic [CNT_W-1:0]          fill_reg, fill_next;

    logic                      out_valid_reg, out_valid_next;
    status_t                   status_reg, status_next;
    logic [COUNT_W-1:0]        count_reg;
    logic signed [WORD_W-1:0]  rdata_reg, rdata_next;

    logic [CMP_W-1:0]          pos_c, cnt_c;
    logic                      do_ins, do_era;

    assign cmd_take = cmd_valid && (!out_valid_reg || pop);
    assign pos_c    = CMP_W'(cmd.index);
    assign cnt_c    = CMP_W'(fill_reg);

    always_comb
    begin
        status_next = ST_OK;
        rdata_next  = '0;
        do_ins      = 1'b0;
        do_era      = 1'b0;
        case (cmd.kind)
            KIND_INSERT:
            begin
                // full is checked ahead of the index
                if (fill_reg == CNT_W'(LIST_DEPTH))
                    status_next = ST_FULL;
                else if (pos_c > cnt_c)
                    status_next = ST_RANGE;
                else
                    do_ins = 1'b1;
            end
            KIND_ERASE:
            begin
                if (pos_c >= cnt_c)
                    status_next = ST_RANGE;
                else
                    do_era = 1'b1;
            end
            KIND_READ:
            begin
                if (pos_c >= cnt_c)
                    status_next = ST_RANGE;
                else
                    rdata_next = entry_reg[pos_c[AW-1:0]];
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (cmd_take && do_ins)
            fill_next = fill_reg + 1'b1;
        else if (cmd_take && do_era)
            fill_next = fill_reg - 1'b1;
    end

    // every cell picks its own source, so the whole list shifts at once
    always_comb
    begin
        for (int k = 0; k < LIST_DEPTH; k++)
        begin
            entry_next[k] = entry_reg[k];
        end
        if (cmd_take && do_ins)
        begin
            for (int k = 1; k < LIST_DEPTH; k++)
            begin
                if (CMP_W'(k) > pos_c && CMP_W'(k) <= cnt_c)
                    entry_next[k] = entry_reg[k-1];
            end
            entry_next[pos_c[AW-1:0]] = cmd.value;
        end
        else if (cmd_take && do_era)
        begin
            for (int k = 0; k < LIST_DEPTH - 1; k++)
            begin
                if (CMP_W'(k) >= pos_c && CMP_W'(k + 1) < cnt_c)
                    entry_next[k] = entry_reg[k+1];
            end
        end
    end

    always_comb
    begin
        if (cmd_take)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < LIST_DEPTH; k++)
        begin
            entry_reg[k] <= entry_next[k];
        end
        if (cmd_take)
        begin
            status_reg <= status_next;
            count_reg  <= COUNT_W'(fill_next);
            rdata_reg  <= rdata_next;
        end
    end

    assign empty      = !out_valid_reg;
    assign status     = status_reg;
    assign count      = count_reg;
    assign read_value = rdata_reg;

endmodule

// File: rtl/indexed_insert_erase_list_core.sv
// Ordered list of up to LIST_DEPTH signed words with insert, erase and read by
// position; each transaction gives one result with a status, the fill count
// after the operation and, for a good read, the entry. Sustained throughput is
// one transaction per cycle while no unpopped result holds the execute stage,
// set by the parallel shift of all register-held entries in that stage; a
// transaction is registered in the command queue and its result in the output
// register before the result shows on the outputs. A two-entry command queue
// and an output register let the push and pop sides stall on their own. Entries
// hold no reset value and need no clearing pass; only positions below the
// count are ever read.
module indexed_insert_erase_list_core import iiel_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic [OP_W-1:0]           op,
    input  logic [INDEX_W-1:0]        index,
    input  logic signed [WORD_W-1:0]  value,
    output logic                      empty,
    input  logic                      pop,
    output logic [STAT_W-1:0]         status,
    output logic [COUNT_W-1:0]        count,
    output logic signed [WORD_W-1:0]  read_value
);

    logic  q_push, q_full, q_empty, q_pop;
    cmd_t  q_cmd, q_head;

    iiel_front u_front
    (
        .push   (push),
        .full   (full),
        .op     (op),
        .index  (index),
        .value  (value),
        .q_push (q_push),
        .q_cmd  (q_cmd),
        .q_full (q_full)
    );

    iiel_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head     (q_head)
    );

    iiel_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (!q_empty),
        .cmd        (q_head),
        .cmd_take   (q_pop),
        .empty      (empty),
        .pop        (pop),
        .status     (status),
        .count      (count),
        .read_value (read_value)
    );

endmodule

// File: rtl/iiel_checker.sv
`include "indexed_insert_erase_list_core_defines.svh"

module iiel_checker import iiel_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      empty,
    input  logic                      pop,
    input  logic [STAT_W-1:0]         status,
    input  logic [COUNT_W-1:0]        count,
    input  logic signed [WORD_W-1:0]  read_value
);

    // a waiting result holds until taken
    `IIEL_ASSERT_NEXT(a_result_hold, !empty && !pop, !empty && $stable({status, count, read_value}))

    // a failed transaction never carries data
    `IIEL_ASSERT_NOW(a_err_no_data, !empty && status != ST_OK, read_value == '0)

    // a full report comes only at the depth limit
    `IIEL_ASSERT_NOW(a_full_at_depth, !empty && status == ST_FULL, count == COUNT_W'(LIST_DEPTH))

    // an empty list has nothing to read or erase
    `IIEL_ASSERT_NOW(a_zero_count_ok, !empty && count == '0 && status == ST_OK, read_value == '0)

endmodule

bind indexed_insert_erase_list_core iiel_checker u_checker (.*);

// File: dv/tb_indexed_insert_erase_list_core.sv
module tb_indexed_insert_erase_list_core import iiel_pkg::*;
;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS   = 1000;
    localparam int MAX_GAP        = 10;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        status_t                   status;
        logic [COUNT_W-1:0]        count;
        logic signed [WORD_W-1:0]  rd;
    } list_result_t;

    typedef struct packed {
        logic [OP_W-1:0]           op;
        logic [INDEX_W-1:0]        index;
        logic signed [WORD_W-1:0]  value;
        logic                      has_literal;
        list_result_t              literal;
    } list_stim_t;

    logic                      clk;
    logic                      rst_n;
    logic                      push;
    logic                      full;
    logic [OP_W-1:0]           op;
    logic [INDEX_W-1:0]        index;
    logic signed [WORD_W-1:0]  value;
    logic                      empty;
    logic                      pop;
    logic [STAT_W-1:0]         status;
    logic [COUNT_W-1:0]        count;
    logic signed [WORD_W-1:0]  read_value;

    // expectation typed into the directed table rides along with the transaction
    logic                      row_has_literal;
    list_result_t              row_literal;

    // shadow of the list contents
    logic signed [WORD_W-1:0]  list_words [LIST_DEPTH];
    int                        list_fill;

    list_result_t              pending_results [$];
    list_stim_t                directed_rows [$];

    int  error_count;
    int  idle_cycles;
    int  plan_fill;
    bit  push_no_idle;
    bit  pop_no_idle;
    int  ops_seen [4];
    int  full_statuses;
    int  range_statuses;
    int  peak_fill;
    int  results_checked;

    indexed_insert_erase_list_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .op         (op),
        .index      (index),
        .value      (value),
        .empty      (empty),
        .pop        (pop),
        .status     (status),
        .count      (count),
        .read_value (read_value)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic list_result_t apply_list_op(input logic [OP_W-1:0] o,
                                                   input logic [INDEX_W-1:0] i,
                                                   input logic signed [WORD_W-1:0] v);
        list_result_t res;
        int k;
        res.status = ST_OK;
        res.rd     = '0;
        case (o)
            OP_INSERT:
            begin
                // full takes priority over a bad index
                if (list_fill >= LIST_DEPTH)
                    res.status = ST_FULL;
                else if (int'(i) > list_fill)
                    res.status = ST_RANGE;
                else
                begin
                    for (k = list_fill; k > int'(i); k--)
                        list_words[k] = list_words[k-1];
                    list_words[i] = v;
                    list_fill++;
                end
            end
            OP_ERASE:
            begin
                if (int'(i) >= list_fill)
                    res.status = ST_RANGE;
                else
                begin
                    for (k = int'(i) + 1; k < list_fill; k++)
                        list_words[k-1] = list_words[k];
                    list_fill--;
                end
            end
            OP_READ:
            begin
                if (int'(i) >= list_fill)
                    res.status = ST_RANGE;
                else
                    res.rd = list_words[i];
            end
            default:
            begin
            end
        endcase
        res.count = COUNT_W'(list_fill);
        return res;
    endfunction

    function automatic list_stim_t dir_row(input logic [OP_W-1:0] o,
                                           input logic [INDEX_W-1:0] i,
                                           input logic signed [WORD_W-1:0] v);
        list_stim_t s;
        s.op          = o;
        s.index       = i;
        s.value       = v;
        s.has_literal = 1'b0;
        s.literal     = '0;
        return s;
    endfunction

    function automatic list_stim_t dir_typed(input logic [OP_W-1:0] o,
                                             input logic [INDEX_W-1:0] i,
                                             input logic signed [WORD_W-1:0] v,
                                             input status_t st,
                                             input logic [COUNT_W-1:0] c,
                                             input logic signed [WORD_W-1:0] rd);
        list_stim_t s;
        s = dir_row(o, i, v);
        s.has_literal    = 1'b1;
        s.literal.status = st;
        s.literal.count  = c;
        s.literal.rd     = rd;
        return s;
    endfunction

    task automatic send_op(input list_stim_t s);
        int gap;
        gap = push_no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push            <= 1'b1;
        op              <= s.op;
        index           <= s.index;
        value           <= s.value;
        row_has_literal <= s.has_literal;
        row_literal     <= s.literal;
        do @(posedge clk); while (full);
        // rough fill tracking to steer indexes toward the valid range
        if (s.op == OP_INSERT && plan_fill < LIST_DEPTH && int'(s.index) <= plan_fill)
            plan_fill++;
        else if (s.op == OP_ERASE && int'(s.index) < plan_fill)
            plan_fill--;
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // result side
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            gap = pop_no_idle ? 0 : $urandom_range(0, MAX_GAP);
            if (gap != 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
        end
    end

    // scoreboard
    always @(posedge clk)
    begin
        list_result_t want;
        list_result_t predicted;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                results_checked++;
                if (pending_results.size() == 0)
                begin
                    error_count++;
                    $display("%0t: result with none expected: status %0d count %0d value %0d",
                             $time, status, count, read_value);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (status !== want.status)
                    begin
                        error_count++;
                        $display("%0t: status mismatch expected %0d actual %0d",
                                 $time, want.status, status);
                    end
                    if (count !== want.count)
                    begin
                        error_count++;
                        $display("%0t: count mismatch expected %0d actual %0d",
                                 $time, want.count, count);
                    end
                    if (read_value !== want.rd)
                    begin
                        error_count++;
                        $display("%0t: read_value mismatch expected %0d actual %0d",
                                 $time, want.rd, read_value);
                    end
                end
            end
            if (push && !full)
            begin
                predicted = apply_list_op(op, index, value);
                pending_results.insert(pending_results.size(),
                                       row_has_literal ? row_literal : predicted);
                ops_seen[op]++;
                if (predicted.status == ST_FULL)
                    full_statuses++;
                if (predicted.status == ST_RANGE)
                    range_statuses++;
                if (list_fill > peak_fill)
                    peak_fill = list_fill;
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles == WATCHDOG_LIMIT)
            begin
                $display("%0t: timeout, no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin
        int n;
        int r;
        int phase;
        int ins_pct;
        int era_pct;
        list_stim_t s;

        rst_n           = 1'b0;
        push            = 1'b0;
        pop             = 1'b0;
        op              = '0;
        index           = '0;
        value           = '0;
        row_has_literal = 1'b0;
        row_literal     = '0;
        list_fill       = 0;
        plan_fill       = 0;
        push_no_idle    = 1'b0;
        pop_no_idle     = 1'b0;
        error_count     = 0;
        idle_cycles     = 0;
        full_statuses   = 0;
        range_statuses  = 0;
        peak_fill       = 0;
        results_checked = 0;
        foreach (ops_seen[k])
            ops_seen[k] = 0;
        foreach (list_words[k])
            list_words[k] = '0;

        directed_rows = '{
            dir_typed(OP_READ,   4'd0,  32'sd0,        ST_RANGE, 5'd0, 32'sd0),
            dir_typed(OP_ERASE,  4'd0,  32'sd0,        ST_RANGE, 5'd0, 32'sd0),
            dir_typed(OP_INSERT, 4'd1,  32'h1234_5678, ST_RANGE, 5'd0, 32'sd0),
            dir_typed(OP_UNUSED, 4'd15, -32'sd1,       ST_OK,    5'd0, 32'sd0),
            dir_typed(OP_INSERT, 4'd0,  32'h8000_0000, ST_OK,    5'd1, 32'sd0),
            dir_typed(OP_INSERT, 4'd1,  32'h7fff_ffff, ST_OK,    5'd2, 32'sd0),
            dir_typed(OP_READ,   4'd0,  32'sd0,        ST_OK,    5'd2, 32'h8000_0000),
            dir_typed(OP_READ,   4'd1,  -32'sd1,       ST_OK,    5'd2, 32'h7fff_ffff),
            // fill up to the top, mixing front, middle and append positions
            dir_row(OP_INSERT, 4'd0,  -32'sd1),
            dir_row(OP_INSERT, 4'd3,  32'sd0),
            dir_row(OP_INSERT, 4'd2,  32'sd1),
            dir_row(OP_INSERT, 4'd5,  32'h5555_5555),
            dir_row(OP_INSERT, 4'd1,  32'haaaa_aaaa),
            dir_row(OP_INSERT, 4'd7,  -32'sd2),
            dir_row(OP_INSERT, 4'd4,  32'h0000_ffff),
            dir_row(OP_INSERT, 4'd9,  32'hffff_0000),
            dir_row(OP_INSERT, 4'd0,  32'h8000_0001),
            dir_row(OP_INSERT, 4'd11, 32'h7fff_fffe),
            dir_row(OP_INSERT, 4'd6,  32'h0f0f_0f0f),
            dir_row(OP_INSERT, 4'd13, 32'hf0f0_f0f0),
            dir_row(OP_INSERT, 4'd10, 32'h1357_9bdf),
            dir_row(OP_INSERT, 4'd15, 32'h2468_ace0),
            dir_typed(OP_INSERT, 4'd15, 32'h0bad_cafe, ST_FULL, 5'd16, 32'sd0),
            dir_row(OP_READ,   4'd15, 32'sd0),
            dir_row(OP_ERASE,  4'd0,  32'sd0)
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[k])
            send_op(directed_rows[k]);
        wait_drained();

        phase = 0;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 100 == 0)
            begin
                if (n % 300 == 0 && n != 0)
                    wait_drained();
                phase        = $urandom_range(0, 2);
                push_no_idle = ($urandom_range(0, 3) == 0);
                pop_no_idle  = ($urandom_range(0, 3) == 0);
            end
            // grow, shrink or steady mix
            case (phase)
                0:
                begin
                    ins_pct = 60;
                    era_pct = 20;
                end
                1:
                begin
                    ins_pct = 25;
                    era_pct = 50;
                end
                default:
                begin
                    ins_pct = 35;
                    era_pct = 30;
                end
            endcase
            s = dir_row(OP_READ, '0, $urandom());
            r = $urandom_range(0, 99);
            if (r < 3)
                s.op = OP_UNUSED;
            else if (r < 3 + ins_pct)
                s.op = OP_INSERT;
            else if (r < 3 + ins_pct + era_pct)
                s.op = OP_ERASE;
            else
                s.op = OP_READ;
            if ($urandom_range(0, 9) == 0 || s.op == OP_UNUSED)
                s.index = INDEX_W'($urandom_range(0, 15));
            else if (s.op == OP_INSERT)
                s.index = INDEX_W'($urandom_range(0, (plan_fill > 15) ? 15 : plan_fill));
            else
                s.index = (plan_fill == 0) ? '0 : INDEX_W'($urandom_range(0, plan_fill - 1));
            if ($urandom_range(0, 7) == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       s.value = 32'h8000_0000;
                    1:       s.value = 32'h7fff_ffff;
                    2:       s.value = 32'sd0;
                    default: s.value = -32'sd1;
                endcase
            end
            send_op(s);
        end

        push <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d results: %0d inserts, %0d erases, %0d reads, %0d unused op",
                 results_checked, ops_seen[OP_INSERT], ops_seen[OP_ERASE], ops_seen[OP_READ],
                 ops_seen[OP_UNUSED]);
        $display("list-full rejects %0d, index-range rejects %0d, peak fill %0d",
                 full_statuses, range_statuses, peak_fill);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
